// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the gray quantizer / bit packer RTL.
// Expects clk_i and rst_ni (active low) in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/gqbp_pkg.sv =====
// Package for the gray quantizer / bit packer: constants, code item type,
// code width helper. No dependencies.
package gqbp_pkg;

  localparam int unsigned ByteBits         = 8;
  localparam int unsigned FifoDepthDefault = 4;
  localparam logic [7:0]  MaxLevelReset    = 8'd255;

  // One quantized code on its way from front to back.
  typedef struct packed {
    logic [7:0] code;   // quantized value, fits in width bits
    logic [3:0] width;  // code width, 1..8
    logic       last;   // final pixel of the image
  } code_item_t;

  // Bits needed to hold level, at least one.
  function automatic logic [3:0] code_width(input logic [7:0] level);
    logic [3:0] w;
    w = 4'd1;
    for (int i = 0; i < 8; i++) begin
      if (level[i]) w = 4'(i + 1);
    end
    return w;
  endfunction

endpackage

// ===== rtl/core/gqbp_front.sv =====
// Front end: accepts pixels, multiplies by max_level, divides by 255 and
// pushes code items to the queue. Depends on gqbp_pkg.
module gqbp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           max_level_i,
  input  logic                 pix_valid_i,
  output logic                 pix_ready_o,
  input  logic [7:0]           pixel_i,
  input  logic                 last_pixel_i,
  output logic                 item_valid_o,
  input  logic                 item_ready_i,
  output gqbp_pkg::code_item_t item_o
);

  logic        prod_valid_q, prod_valid_d;
  logic [15:0] prod_q, prod_d;
  logic [3:0]  width_q, width_d;   // width taken with the same level as the product
  logic        last_q, last_d;
  logic [16:0] quot_sum;
  logic        take;

  assign pix_ready_o = !prod_valid_q || item_ready_i;
  assign take        = pix_valid_i && pix_ready_o;

  always_comb begin
    prod_valid_d = prod_valid_q;
    prod_d       = prod_q;
    width_d      = width_q;
    last_d       = last_q;
    if (take) begin
      prod_valid_d = 1'b1;
      prod_d       = pixel_i * max_level_i;
      width_d      = gqbp_pkg::code_width(max_level_i);
      last_d       = last_pixel_i;
    end else if (item_ready_i) begin
      prod_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else begin
      prod_valid_q <= prod_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    width_q <= width_d;
    last_q  <= last_d;
  end

  // floor(p/255) = (p + (p >> 8) + 1) >> 8, exact for p up to 65534, so for every 8-bit product
  assign quot_sum = {1'b0, prod_q} + 17'(prod_q[15:8]) + 17'd1;

  assign item_valid_o = prod_valid_q;
  assign item_o.code  = quot_sum[15:8];
  assign item_o.width = width_q;
  assign item_o.last  = last_q;

endmodule

// ===== rtl/core/gqbp_fifo.sv =====
// Short queue of code items between front and back.
// Depends on gqbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gqbp_fifo #(
  parameter int unsigned Depth = gqbp_pkg::FifoDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  gqbp_pkg::code_item_t in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output gqbp_pkg::code_item_t out_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  gqbp_pkg::code_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic push, pop;

  assign in_ready_o  = count_q != CntW'(Depth);
  assign out_valid_o = count_q != '0;
  assign out_item_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + PtrW'(1));
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + PtrW'(1));
    end
    if (push && !pop) begin
      count_d = CntW'(count_q + CntW'(1));
    end else if (pop && !push) begin
      count_d = CntW'(count_q - CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  `ASSERT_NEVER(a_fifo_overfill, count_q > CntW'(Depth), "fifo count above depth")
  `ASSERT_CLK(a_fifo_inc, (push && !pop) |=> count_q == CntW'($past(count_q) + 1'b1), "fifo count did not grow")
  `ASSERT_CLK(a_fifo_dec, (pop && !push) |=> count_q == CntW'($past(count_q) - 1'b1), "fifo count did not shrink")

endmodule

// ===== rtl/core/gqbp_back.sv =====
// Back end: packs codes MSB first into bytes and drives the output register.
// Depends on gqbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gqbp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  output logic                 item_ready_o,
  input  gqbp_pkg::code_item_t item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o
);

  localparam logic [3:0] FullFree = 4'(gqbp_pkg::ByteBits);

  logic [7:0] partial_q, partial_d;
  logic [3:0] free_q, free_d;
  logic       flush_q, flush_d;     // partial byte still owed after a split last code
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;

  logic       out_free;
  logic [3:0] avail, rem, left;
  logic [7:0] merged;

  assign out_free     = !out_valid_q || out_ready_i;
  assign item_ready_o = out_free && !flush_q;

  always_comb begin
    avail = ((free_q == 4'd0) || (free_q > FullFree)) ? FullFree : free_q;
    rem   = item_i.width - avail;
    left  = avail - item_i.width;
    merged = '0;

    partial_d   = partial_q;
    free_d      = free_q;
    flush_d     = flush_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    priority if (flush_q && out_free) begin
      out_valid_d = 1'b1;
      out_byte_d  = partial_q;
      out_last_d  = 1'b1;
      partial_d   = '0;
      free_d      = FullFree;
      flush_d     = 1'b0;
    end else if (item_valid_i && item_ready_o) begin
      if (item_i.width <= avail) begin
        merged = partial_q | 8'(item_i.code << left);
        if (left == 4'd0 || item_i.last) begin
          // byte full, or last pixel: send it out padded
          out_valid_d = 1'b1;
          out_byte_d  = merged;
          out_last_d  = item_i.last;
          partial_d   = '0;
          free_d      = FullFree;
        end else begin
          partial_d = merged;
          free_d    = left;
        end
      end else begin
        // code straddles the byte boundary
        out_valid_d = 1'b1;
        out_byte_d  = partial_q | (item_i.code >> rem);
        out_last_d  = 1'b0;
        partial_d   = 8'(item_i.code << (FullFree - rem));
        free_d      = FullFree - rem;
        flush_d     = item_i.last;
      end
    end else begin
      // nothing to do this cycle
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      free_q      <= FullFree;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      partial_q   <= partial_d;
      free_q      <= free_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  `ASSERT_NEVER(a_free_range, free_q == 4'd0 || free_q > FullFree, "free bit count out of range")
  `ASSERT_CLK(a_empty_clean, free_q == FullFree |-> partial_q == '0, "empty byte holds stale bits")
  `ASSERT_CLK(a_flush_out, flush_q |-> out_valid_q, "flush pending without the split byte")
  `ASSERT_CLK(a_flush_done, $fell(flush_q) |-> (free_q == FullFree && out_last_q), "flush left state behind")

endmodule

// ===== rtl/core/gray_quantize_bit_packer_unit.sv =====
// Top level of the gray quantizer / bit packer: config register, front end,
// code queue and packing back end. Depends on gqbp_pkg, gqbp_front, gqbp_fifo, gqbp_back.
//
//  channel   dir  tdata / data          side band        transfer when
//  s_axis    in   [7:0] pixel           tlast=last_pixel tvalid & tready
//  m_axis    out  [7:0] packed_byte     tlast=last_byte  tvalid & tready
//  cfg       in   [7:0] max_level       -                cfg_valid_i & cfg_ready_o
//
// One pixel per cycle sustained while no output stall or flush holds the back end;
// a pixel passes the multiply register, the queue and the output register to its byte.
// The back end takes one code per cycle unless its output is stalled or a flush is owed;
// it emits at most one byte per cycle, and a straddling last code adds a flush byte.
// Reset: max_level = 255, packing byte empty with 8 free bits, queue empty.
// Output stalls back up through the queue into s_axis_tready; input stalls
// never hold back a byte already in the output register.
module gray_quantize_bit_packer_unit #(
  parameter int unsigned FifoDepth = gqbp_pkg::FifoDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // pixel stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] pixel
  input  logic       s_axis_tlast,   // last_pixel
  // packed byte stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] packed_byte
  output logic       m_axis_tlast,   // last_byte
  // max_level register write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic [7:0] max_level_q, max_level_d;

  logic                 fr_valid, fr_ready;
  gqbp_pkg::code_item_t fr_item;
  logic                 bk_valid, bk_ready;
  gqbp_pkg::code_item_t bk_item;

  // A write applies to pixels transferred after it; scale and width travel
  // with each code, so items already in flight keep their level.
  assign cfg_ready_o = 1'b1;
  assign max_level_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : max_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= gqbp_pkg::MaxLevelReset;
    end else begin
      max_level_q <= max_level_d;
    end
  end

  // Quantize: code = floor(pixel * max_level / 255), width from max_level.
  gqbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_level_i  (max_level_q),
    .pix_valid_i  (s_axis_tvalid),
    .pix_ready_o  (s_axis_tready),
    .pixel_i      (s_axis_tdata),
    .last_pixel_i (s_axis_tlast),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  // Decouples the quantizer from output backpressure.
  gqbp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_item_i   (fr_item),
    .out_valid_o (bk_valid),
    .out_ready_i (bk_ready),
    .out_item_o  (bk_item)
  );

  // MSB-first packing into bytes, flush of the partial byte on last pixel.
  gqbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (bk_valid),
    .item_ready_o (bk_ready),
    .item_i       (bk_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for gray_quantize_bit_packer_unit: directed and random pixel
// streams, max_level writes, receiver hold-off. Depends on gqbp_pkg and the RTL top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HoldCycles  = 300;  // long receiver hold-off
  localparam int unsigned DrainCycles = 8;    // pipeline latency plus margin

  // One byte the packer must emit.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;   // [7:0] pixel
  logic       s_axis_tlast  = 1'b0; // last_pixel
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // [7:0] packed_byte
  logic       m_axis_tlast;         // last_byte
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i    = '0;

  // Packer state as the checker sees it.
  logic [7:0]   level_q   = gqbp_pkg::MaxLevelReset;
  logic [7:0]   partial_q = '0;
  int unsigned  free_q    = gqbp_pkg::ByteBits;
  packed_byte_t expected_bytes[$];

  int err_cnt       = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;  // bumped to start a receiver hold-off
  int hold_seen     = 0;
  int hold_left     = 0;

  gray_quantize_bit_packer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Number of bits that hold a level, never below one.
  function automatic int unsigned level_bits(input logic [7:0] level);
    int unsigned n;
    n = 0;
    for (int unsigned v = level; v != 0; v = v >> 1) n++;
    return (n == 0) ? 1 : n;
  endfunction

  // Requantize one pixel, pack its code MSB first, queue any finished bytes.
  function automatic void pack_pixel(input logic [7:0] pix, input logic last);
    int unsigned width;
    int unsigned code;
    int unsigned spill;
    width = level_bits(level_q);
    code  = (int'(pix) * int'(level_q)) / 255;
    if (width <= free_q) begin
      partial_q = partial_q | 8'(code << (free_q - width));
      free_q    = free_q - width;
      if (free_q == 0) begin
        expected_bytes.push_back('{partial_q, last});
        partial_q = '0;
        free_q    = gqbp_pkg::ByteBits;
      end
    end else begin
      // code straddles: high bits close this byte, low bits open the next
      spill     = width - free_q;
      partial_q = partial_q | 8'(code >> spill);
      expected_bytes.push_back('{partial_q, 1'b0});
      partial_q = 8'(code << (gqbp_pkg::ByteBits - spill));
      free_q    = gqbp_pkg::ByteBits - spill;
    end
    if (last && free_q < gqbp_pkg::ByteBits) begin
      expected_bytes.push_back('{partial_q, 1'b1});
      partial_q = '0;
      free_q    = gqbp_pkg::ByteBits;
    end
  endfunction

  // Receiver: random back-pressure, or a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Byte checker: every output transfer against the oldest expected byte.
  always @(posedge clk_i) begin
    packed_byte_t exp_b;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte data=%h last=%b", $time, m_axis_tdata, m_axis_tlast);
        err_cnt++;
      end else begin
        exp_b = expected_bytes.pop_front();
        if (m_axis_tdata !== exp_b.data) begin
          $display("%0t: packed_byte mismatch expected=%h actual=%h",
                   $time, exp_b.data, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tlast !== exp_b.last) begin
          $display("%0t: last_byte mismatch expected=%b actual=%b",
                   $time, exp_b.last, m_axis_tlast);
          err_cnt++;
        end
      end
    end
  end

  // One pixel transfer, with random sender idle cycles ahead of it.
  task automatic send_pixel(input logic [7:0] pix, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    pack_pixel(pix, last);
  endtask

  // Let every expected byte come out, then let the pipeline settle.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // max_level write, only with the block idle.
  task automatic set_level(input logic [7:0] level);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= level;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    level_q = level;
  endtask

  // Extremes, all-zero level, splits, flush cases, level change mid-byte.
  task automatic test_directed;
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);        // full byte at reset level, last
    set_level(8'd0);                 // width 1, every code zero
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd200, 1'b1);        // partial flush
    set_level(8'd1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);
    set_level(8'd7);                 // width 3: codes straddle bytes
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b1);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b1);        // last straddles: two bytes
    set_level(8'd15);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b1);        // last fills the byte exactly
    send_pixel(8'd128, 1'b0);        // leave half a byte
    set_level(8'd63);                // bits already packed stay
    send_pixel(8'd255, 1'b0);
    set_level(8'd255);
    send_pixel(8'h5a, 1'b1);
    drain();
  endtask

  // Receiver holds off while the sender keeps offering pixels.
  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_level(8'd255);
    hold_req <= hold_req + 1;
    for (int i = 0; i < 40; i++) send_pixel(8'($urandom), 1'b0);
    send_pixel(8'($urandom), 1'b1);
    drain();
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd1;
      3:       return 8'd128;
      default: return 8'($urandom);
    endcase
  endfunction

  // Random images under changing levels; level writes land mid-byte too.
  task automatic test_random(input int n, input int spct, input int rpct);
    int until_cfg;
    logic [7:0] pix;
    send_idle_pct = spct;
    recv_idle_pct = rpct;
    until_cfg = $urandom_range(30, 90);
    for (int i = 0; i < n; i++) begin
      if (until_cfg == 0) begin
        set_level(pick_level());
        until_cfg = $urandom_range(30, 90);
      end
      until_cfg--;
      case ($urandom_range(9))
        0:       pix = 8'd0;
        1:       pix = 8'd255;
        default: pix = 8'($urandom);
      endcase
      send_pixel(pix, ($urandom_range(15) == 0));
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 20;
    recv_idle_pct = 77;
    test_directed();
    test_random(320, 20, 77);
    test_random(320, 77, 20);
    test_backpressure();
    test_random(310, 0, 0);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/gqbp_pkg.sv
rtl/core/gqbp_front.sv
rtl/core/gqbp_fifo.sv
rtl/core/gqbp_back.sv
rtl/core/gray_quantize_bit_packer_unit.sv
bench/testbench.sv
